>>> sv/cdae_pkg.sv
// Shared types, constants and step functions for the color distance alpha estimator.
package cdae_pkg;

  localparam int unsigned CH_W   = 8;   // one color channel
  localparam int unsigned BAND_W = 7;   // band half width register
  localparam int unsigned IDX_W  = 3;   // configuration register index

  localparam logic [7:0] CD_FULL = 8'd255;
  localparam logic [7:0] CD_MID  = 8'd128;

  localparam logic [7:0]  FG_RST   = 8'd255;
  localparam logic [7:0]  BG_RST   = 8'd0;
  localparam logic [6:0]  BAND_RST = 7'd64;

  typedef enum logic [IDX_W-1:0] {
    CFG_FG_RED   = 3'd0,
    CFG_FG_GREEN = 3'd1,
    CFG_FG_BLUE  = 3'd2,
    CFG_BG_RED   = 3'd3,
    CFG_BG_GREEN = 3'd4,
    CFG_BG_BLUE  = 3'd5,
    CFG_BAND     = 3'd6
  } cfg_reg_e;

  // Digit-by-digit square root state: radicand bits still to consume (MSB first),
  // partial remainder and partial root.
  typedef struct packed {
    logic [17:0] rad;
    logic [9:0]  rem;
    logic [8:0]  root;
  } sqrt_t;

  // Restoring division state: partial remainder, shifted divisor, quotient so far.
  typedef struct packed {
    logic [16:0] rem;
    logic [16:0] den;
    logic [7:0]  quo;
  } div_t;

  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [11:0] acc;
    logic [11:0] trial;
    sqrt_t       r;
    acc   = {s.rem, s.rad[17:16]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[15:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = 10'(acc - trial);
      r.root = {s.root[7:0], 1'b1};
    end else begin
      r.rem  = acc[9:0];
      r.root = {s.root[7:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_t div_step(div_t s);
    div_t r;
    r.den = {1'b0, s.den[16:1]};
    if (s.rem >= s.den) begin
      r.rem = s.rem - s.den;
      r.quo = {s.quo[6:0], 1'b1};
    end else begin
      r.rem = s.rem;
      r.quo = {s.quo[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

>>> sv/cdae_if.sv
// Handshake channel interfaces for pixels, results and configuration writes.
interface cdae_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_red;
  logic [7:0] pix_green;
  logic [7:0] pix_blue;

  modport source (output valid, output pix_red, output pix_green, output pix_blue,
                  input ready);
  modport sink   (input valid, input pix_red, input pix_green, input pix_blue,
                  output ready);
endinterface

interface cdae_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha;
  logic       in_band;

  modport source (output valid, output alpha, output in_band, input ready);
  modport sink   (input valid, input alpha, input in_band, output ready);
endinterface

interface cdae_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/color_distance_alpha_estimator_unit.sv
// Pipelined color distance alpha estimator: one pixel in, one alpha result out.
//
// The unit accepts one pixel per cycle while the result side is not stalled, and
// returns one result per pixel, in order. Most of its stages belong to the floor
// square roots (three stages of three digit steps each) and to the two 8-bit restoring
// dividers (four stages of two quotient bits each); every stage holds
// its own valid bit and a stage advances whenever it is empty or its successor advances,
// so bubbles collapse and a stall on the result side backs up without loss. Registers
// are written through the configuration channel (index 0..6: foreground red, green,
// blue, background red, green, blue, band half width); writes to index 7 are dropped,
// a band half width of zero acts as one, and configuration is to be changed only while
// no pixel is in flight.
module color_distance_alpha_estimator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdae_pix_if.sink    pix_i,
  cdae_res_if.source  res_o,
  cdae_cfg_if.sink    cfg_i
);

  // Stage map
  localparam int unsigned ST_SQ    = 0;   // channel differences squared
  localparam int unsigned ST_SUM   = 1;   // squared distances summed; stages 2..4: roots
  localparam int unsigned SQRT_N   = 3;
  localparam int unsigned ST_DIV1  = 5;   // stage 5 setup, 6..9 raw ratio division
  localparam int unsigned ST_MAP   = 10;  // stage 10 band mapping, 11..14 ramp division
  localparam int unsigned DIV_N    = 4;
  localparam int unsigned NUM_ST   = 15;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] fg_red_q, fg_green_q, fg_blue_q;
  logic [7:0] bg_red_q, bg_green_q, bg_blue_q;
  logic [6:0] band_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_red_q   <= cdae_pkg::FG_RST;
      fg_green_q <= cdae_pkg::FG_RST;
      fg_blue_q  <= cdae_pkg::FG_RST;
      bg_red_q   <= cdae_pkg::BG_RST;
      bg_green_q <= cdae_pkg::BG_RST;
      bg_blue_q  <= cdae_pkg::BG_RST;
      band_q     <= cdae_pkg::BAND_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        cdae_pkg::CFG_FG_RED:   fg_red_q   <= cfg_i.data;
        cdae_pkg::CFG_FG_GREEN: fg_green_q <= cfg_i.data;
        cdae_pkg::CFG_FG_BLUE:  fg_blue_q  <= cfg_i.data;
        cdae_pkg::CFG_BG_RED:   bg_red_q   <= cfg_i.data;
        cdae_pkg::CFG_BG_GREEN: bg_green_q <= cfg_i.data;
        cdae_pkg::CFG_BG_BLUE:  bg_blue_q  <= cfg_i.data;
        cdae_pkg::CFG_BAND:     band_q     <= cfg_i.data[6:0];
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage advances when empty or when its successor advances
  // ---------------------------------------------------------------------------
  logic [NUM_ST-1:0] valid_q;
  logic [NUM_ST:0]   adv;

  always_comb begin
    adv[NUM_ST] = res_o.ready;
    for (int k = NUM_ST - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign pix_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NUM_ST; k++) begin
        if (adv[k]) begin
          valid_q[k] <= (k == 0) ? pix_i.valid : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: absolute channel differences squared
  // ---------------------------------------------------------------------------
  logic [7:0]  pix_ch [3];
  logic [7:0]  fg_ch  [3];
  logic [7:0]  bg_ch  [3];
  logic [15:0] sq_fg_d [3];
  logic [15:0] sq_bg_d [3];
  logic [15:0] sq_fg_q [3];
  logic [15:0] sq_bg_q [3];

  assign pix_ch = '{pix_i.pix_red, pix_i.pix_green, pix_i.pix_blue};
  assign fg_ch  = '{fg_red_q, fg_green_q, fg_blue_q};
  assign bg_ch  = '{bg_red_q, bg_green_q, bg_blue_q};

  always_comb begin
    logic [7:0] dif_fg;
    logic [7:0] dif_bg;
    for (int c = 0; c < 3; c++) begin
      dif_fg = (pix_ch[c] > fg_ch[c]) ? pix_ch[c] - fg_ch[c] : fg_ch[c] - pix_ch[c];
      dif_bg = (pix_ch[c] > bg_ch[c]) ? pix_ch[c] - bg_ch[c] : bg_ch[c] - pix_ch[c];
      sq_fg_d[c] = 16'(dif_fg) * 16'(dif_fg);
      sq_bg_d[c] = 16'(dif_bg) * 16'(dif_bg);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_SQ]) begin
      sq_fg_q <= sq_fg_d;
      sq_bg_q <= sq_bg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: sum of squares seeds the root; stages 2..4: three root digits each
  // ---------------------------------------------------------------------------
  cdae_pkg::sqrt_t sqt_fg_q [SQRT_N+1];
  cdae_pkg::sqrt_t sqt_bg_q [SQRT_N+1];
  cdae_pkg::sqrt_t sqt_fg_d [SQRT_N+1];
  cdae_pkg::sqrt_t sqt_bg_d [SQRT_N+1];

  always_comb begin
    sqt_fg_d[0].rad  = 18'(sq_fg_q[0]) + 18'(sq_fg_q[1]) + 18'(sq_fg_q[2]);
    sqt_fg_d[0].rem  = '0;
    sqt_fg_d[0].root = '0;
    sqt_bg_d[0].rad  = 18'(sq_bg_q[0]) + 18'(sq_bg_q[1]) + 18'(sq_bg_q[2]);
    sqt_bg_d[0].rem  = '0;
    sqt_bg_d[0].root = '0;
    for (int j = 1; j <= SQRT_N; j++) begin
      sqt_fg_d[j] = sqt_fg_q[j-1];
      sqt_bg_d[j] = sqt_bg_q[j-1];
      for (int s = 0; s < 3; s++) begin
        sqt_fg_d[j] = cdae_pkg::sqrt_step(sqt_fg_d[j]);
        sqt_bg_d[j] = cdae_pkg::sqrt_step(sqt_bg_d[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= SQRT_N; j++) begin
      if (adv[ST_SUM+j]) begin
        sqt_fg_q[j] <= sqt_fg_d[j];
        sqt_bg_q[j] <= sqt_bg_d[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: set up raw = 255*dbg / (dfg+dbg); stages 6..9: two quotient bits each
  // ---------------------------------------------------------------------------
  cdae_pkg::div_t div1_q [DIV_N+1];
  cdae_pkg::div_t div1_d [DIV_N+1];

  always_comb begin
    logic [8:0] dist_fg;
    logic [8:0] dist_bg;
    logic [9:0] dist_sum;
    dist_fg  = sqt_fg_q[SQRT_N].root;
    dist_bg  = sqt_bg_q[SQRT_N].root;
    dist_sum = 10'(dist_fg) + 10'(dist_bg);
    div1_d[0].quo = '0;
    if (dist_sum == '0) begin
      // Pixel, foreground and background coincide: divide 128 by 1 for the midpoint
      div1_d[0].rem = 17'(cdae_pkg::CD_MID);
      div1_d[0].den = 17'(cdae_pkg::CD_MID);
    end else begin
      div1_d[0].rem = {dist_bg, 8'h00} - 17'(dist_bg);
      div1_d[0].den = {dist_sum, 7'h00};
    end
    for (int j = 1; j <= DIV_N; j++) begin
      div1_d[j] = cdae_pkg::div_step(cdae_pkg::div_step(div1_q[j-1]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= DIV_N; j++) begin
      if (adv[ST_DIV1+j]) begin
        div1_q[j] <= div1_d[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: place raw against the band; stages 11..14: ramp division.
  // Saturated results run through the divider as 0/1 or 255/1.
  // ---------------------------------------------------------------------------
  cdae_pkg::div_t    div2_q [DIV_N+1];
  cdae_pkg::div_t    div2_d [DIV_N+1];
  logic [DIV_N:0]    flag_q;
  logic              flag_d;

  always_comb begin
    logic [7:0] raw;
    logic [6:0] band;
    logic [8:0] raw_pb;
    logic [7:0] ramp;
    raw    = div1_q[DIV_N].quo;
    band   = (band_q == '0) ? 7'd1 : band_q;
    raw_pb = 9'(raw) + 9'(band);
    ramp   = 8'(raw_pb - 9'(cdae_pkg::CD_MID));
    div2_d[0].quo = '0;
    if (raw_pb < 9'(cdae_pkg::CD_MID)) begin
      div2_d[0].rem = '0;
      div2_d[0].den = 17'(cdae_pkg::CD_MID);
      flag_d        = 1'b0;
    end else if (9'(raw) > 9'(cdae_pkg::CD_MID) + 9'(band)) begin
      div2_d[0].rem = 17'(cdae_pkg::CD_FULL);
      div2_d[0].den = 17'(cdae_pkg::CD_MID);
      flag_d        = 1'b0;
    end else begin
      div2_d[0].rem = 17'({ramp, 8'h00} - 16'(ramp));
      div2_d[0].den = 17'({band, 1'b0, 7'h00});
      flag_d        = 1'b1;
    end
    for (int j = 1; j <= DIV_N; j++) begin
      div2_d[j] = cdae_pkg::div_step(cdae_pkg::div_step(div2_q[j-1]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= DIV_N; j++) begin
      if (adv[ST_MAP+j]) begin
        div2_q[j] <= div2_d[j];
        flag_q[j] <= (j == 0) ? flag_d : flag_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result
  // ---------------------------------------------------------------------------
  assign res_o.valid   = valid_q[NUM_ST-1];
  assign res_o.alpha   = div2_q[DIV_N].quo;
  assign res_o.in_band = flag_q[DIV_N];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Out-of-band pixels saturate to fully background or fully foreground.
  a_sat_outside_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.in_band |-> res_o.alpha == 8'd0 || res_o.alpha == 8'd255)
    else $error("out-of-band result is not saturated");

  // An empty result stage frees the whole pipeline.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[NUM_ST-1] |-> pix_i.ready)
    else $error("input blocked with an empty result stage");

  // A held item in the square root seed stage is not lost.
  a_hold_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_SUM] && !adv[ST_SUM] |=> valid_q[ST_SUM])
    else $error("stalled pipeline stage dropped its item");

  // The ramp divisor is never zero for an in-band pixel.
  a_ramp_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_MAP] && flag_q[0] |-> div2_q[0].den != '0)
    else $error("zero ramp divisor");

endmodule

>>> sim/alpha_estimate_check.sv
// Checker for the alpha estimator: tracks the register writes, predicts each result, compares.
module alpha_estimate_check (
  input  logic clk_i,
  input  logic rst_ni,
  cdae_pix_if  pix_i,
  cdae_res_if  res_i,
  cdae_cfg_if  cfg_i,
  output int   err_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [23:0] pixel;   // {blue, green, red}
    logic [7:0]  alpha;
    logic        in_band;
  } alpha_pred_t;

  logic [2:0][7:0] fg_col;   // [0] red, [1] green, [2] blue
  logic [2:0][7:0] bg_col;
  logic [6:0]      band_hw;
  alpha_pred_t     alpha_q[$];
  int              errors = 0;

  assign err_cnt_o = errors;

  task automatic report(string msg);
    if (errors < PRINT_CAP) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned floor_root(int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 8; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic int unsigned color_dist(logic [2:0][7:0] p, logic [2:0][7:0] c);
    int unsigned acc;
    int          d;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      d = int'(p[k]) - int'(c[k]);
      acc += d * d;
    end
    return floor_root(acc);
  endfunction

  function automatic alpha_pred_t estimate_alpha(logic [2:0][7:0] p);
    int unsigned d_fg;
    int unsigned d_bg;
    int unsigned total;
    int unsigned ratio;
    int unsigned band;
    int unsigned a;
    alpha_pred_t e;
    d_fg  = color_dist(p, fg_col);
    d_bg  = color_dist(p, bg_col);
    total = d_fg + d_bg;
    // a pixel sitting on both colors at once lands on the band center
    ratio = (total == 0) ? int'(cdae_pkg::CD_MID)
                         : (int'(cdae_pkg::CD_FULL) * d_bg) / total;
    band  = (band_hw == 0) ? 1 : int'(band_hw);
    e.pixel = p;
    if (ratio + band < int'(cdae_pkg::CD_MID)) begin
      e.alpha   = '0;
      e.in_band = 1'b0;
    end else if (ratio > int'(cdae_pkg::CD_MID) + band) begin
      e.alpha   = cdae_pkg::CD_FULL;
      e.in_band = 1'b0;
    end else begin
      a = (int'(cdae_pkg::CD_FULL) * (ratio + band - int'(cdae_pkg::CD_MID))) / (2 * band);
      if (a > int'(cdae_pkg::CD_FULL)) a = int'(cdae_pkg::CD_FULL);
      e.alpha   = a[7:0];
      e.in_band = 1'b1;
    end
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_col  <= {3{cdae_pkg::FG_RST}};
      bg_col  <= {3{cdae_pkg::BG_RST}};
      band_hw <= cdae_pkg::BAND_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        cdae_pkg::CFG_FG_RED:   fg_col[0] <= cfg_i.data;
        cdae_pkg::CFG_FG_GREEN: fg_col[1] <= cfg_i.data;
        cdae_pkg::CFG_FG_BLUE:  fg_col[2] <= cfg_i.data;
        cdae_pkg::CFG_BG_RED:   bg_col[0] <= cfg_i.data;
        cdae_pkg::CFG_BG_GREEN: bg_col[1] <= cfg_i.data;
        cdae_pkg::CFG_BG_BLUE:  bg_col[2] <= cfg_i.data;
        cdae_pkg::CFG_BAND:     band_hw   <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : watch
    alpha_pred_t want;
    if (rst_ni) begin
      if (res_i.valid && res_i.ready) begin
        if (alpha_q.size() == 0) begin
          report($sformatf("result alpha %0d in_band %0b with no pixel pending",
                           res_i.alpha, res_i.in_band));
        end else begin
          want = alpha_q.pop_front();
          if (res_i.alpha !== want.alpha)
            report($sformatf("pixel %06h: alpha %0d, want %0d",
                             want.pixel, res_i.alpha, want.alpha));
          if (res_i.in_band !== want.in_band)
            report($sformatf("pixel %06h: in_band %0b, want %0b",
                             want.pixel, res_i.in_band, want.in_band));
        end
      end
      if (pix_i.valid && pix_i.ready)
        alpha_q.push_back(estimate_alpha({pix_i.pix_blue, pix_i.pix_green, pix_i.pix_red}));
    end
    pending_o <= alpha_q.size();
  end

endmodule

>>> sim/color_distance_alpha_estimator_unit_test.sv
// Top of the alpha estimator test: clock, reset, stimulus, result back-pressure, verdict.
module color_distance_alpha_estimator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Index 7 has no register behind it; writes there must be dropped.
  localparam logic [cdae_pkg::IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 225;  // 8 phases of 225 pixels
  localparam int QUIET_BLOCK = 75;   // items between decisions on idling
  localparam int DRAIN       = 30;   // pipeline is 15 deep; leave margin

  logic clk_i;
  logic rst_ni;
  logic quiet;   // when set, neither side inserts gaps or stalls

  // Colors currently programmed, used to aim random pixels at the band.
  logic [2:0][7:0] fg_set;   // [0] red, [1] green, [2] blue
  logic [2:0][7:0] bg_set;

  int err_cnt;
  int pending;

  cdae_pix_if pix ();
  cdae_res_if res ();
  cdae_cfg_if cfg ();

  color_distance_alpha_estimator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  alpha_estimate_check u_alpha_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix),
    .res_i     (res),
    .cfg_i     (cfg),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int idle_gap();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: alternate stall stretches with ready stretches.
  initial begin : result_ready
    int stall;
    res.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_gap();
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Offer one pixel and hold it until the transfer. Valid stays high into the
  // next call when no gap is drawn, so it is never dropped and raised in one step.
  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid     <= 1'b1;
    pix.pix_red   <= r;
    pix.pix_green <= g;
    pix.pix_blue  <= b;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  // Random pixel: mostly a blend of the two colors with a little noise, so the
  // ratio sweeps across the band; some exact hits on either color; some anywhere.
  task automatic push_shaped_pixel();
    logic [2:0][7:0] p;
    int              t;
    int              v;
    t = $urandom_range(0, 256);
    for (int k = 0; k < 3; k++) begin
      v = (int'(fg_set[k]) * t + int'(bg_set[k]) * (256 - t)) / 256
          + int'($urandom_range(0, 12)) - 6;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      p[k] = v[7:0];
    end
    case ($urandom_range(0, 9))
      0:       p = fg_set;
      1:       p = bg_set;
      2, 3:    p = 24'($urandom());
      default: ;
    endcase
    push_pixel(p[0], p[1], p[2]);
  endtask

  // One register transfer; valid is left high for a following write.
  task automatic write_reg(logic [cdae_pkg::IDX_W-1:0] idx, logic [7:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
  endtask

  // Program all seven registers, then poke the unused index with junk.
  task automatic apply_setting(logic [2:0][7:0] f, logic [2:0][7:0] bk, logic [7:0] band);
    fg_set = f;
    bg_set = bk;
    write_reg(cdae_pkg::CFG_FG_RED,   f[0]);
    write_reg(cdae_pkg::CFG_FG_GREEN, f[1]);
    write_reg(cdae_pkg::CFG_FG_BLUE,  f[2]);
    write_reg(cdae_pkg::CFG_BG_RED,   bk[0]);
    write_reg(cdae_pkg::CFG_BG_GREEN, bk[1]);
    write_reg(cdae_pkg::CFG_BG_BLUE,  bk[2]);
    write_reg(cdae_pkg::CFG_BAND,     band);
    write_reg(CFG_SPARE_IDX, 8'($urandom()));
    cfg.valid <= 1'b0;
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline settle.
  task automatic drain_results();
    pix.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [2:0][7:0] f;
    logic [2:0][7:0] bk;
    logic [7:0]      band;
    pix.valid     = 1'b0;
    pix.pix_red   = '0;
    pix.pix_green = '0;
    pix.pix_blue  = '0;
    cfg.valid     = 1'b0;
    cfg.index     = '0;
    cfg.data      = '0;
    quiet         = 1'b0;
    fg_set        = {3{cdae_pkg::FG_RST}};
    bg_set        = {3{cdae_pkg::BG_RST}};
    rst_ni        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset colors (white on black, band 64): all cube corners and three greys.
    for (int c = 0; c < 8; c++)
      push_pixel(c[0] ? 8'd255 : 8'd0, c[1] ? 8'd255 : 8'd0, c[2] ? 8'd255 : 8'd0);
    push_pixel(8'd64, 8'd64, 8'd64);
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd192, 8'd192, 8'd192);
    drain_results();

    // Both colors equal and band zero (acts as one): a pixel on that color has
    // both distances zero and must land on the band center.
    apply_setting({8'd20, 8'd150, 8'd77}, {8'd20, 8'd150, 8'd77}, 8'd0);
    push_pixel(8'd77, 8'd150, 8'd20);
    push_pixel(8'd0, 8'd0, 8'd0);
    drain_results();

    // Black on white, band written with bit 7 set (masks to 127, the widest).
    apply_setting({3{8'd0}}, {3{8'd255}}, 8'hFF);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd1, 8'd0, 8'd255);
    drain_results();

    // Random phases, the first two at the color and band extremes.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      f  = 24'($urandom());
      bk = 24'($urandom());
      case ($urandom_range(0, 5))
        0:       band = 8'd0;
        1:       band = 8'd1;
        2:       band = 8'd127;
        3:       band = 8'h80 | 8'($urandom_range(0, 127));
        default: band = 8'($urandom_range(1, 127));
      endcase
      if (ph == 0) begin
        f    = {3{8'd255}};
        bk   = {3{8'd0}};
        band = 8'd1;
      end else if (ph == 1) begin
        f    = {3{8'd0}};
        bk   = {3{8'd255}};
        band = 8'd127;
      end else if ($urandom_range(0, 5) == 0) begin
        bk = f;
      end
      apply_setting(f, bk, band);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold idling off for some whole blocks so back-to-back runs happen
        if (n % QUIET_BLOCK == 0) quiet = ($urandom_range(0, 3) == 0);
        push_shaped_pixel();
      end
      quiet = 1'b0;
      drain_results();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
